/* rtl/core/gbn_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the go-back-N sender window.
// Used by gbn_ctrl, gbn_dpath and the top level; depends on nothing.
package gbn_pkg;

    localparam int MAX_WINDOW_DEF  = 8;
    localparam int SEQ_BITS_DEF    = 16;
    localparam int MAX_PAYLOAD_DEF = 512;

    localparam int CFG_W = 4;
    localparam logic [CFG_W-1:0] WINDOW_RESET = 4'd5;
    localparam logic [15:0] RETRY_MAX = 16'hFFFF;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_NAME = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;
    localparam logic [1:0] KIND_EOT  = 2'd3;

    typedef enum logic [1:0] {
        OP_NEW    = 2'd0,
        OP_ACK    = 2'd1,
        OP_ROUND  = 2'd2,
        OP_FINISH = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ACT_STATUS = 2'd0,
        ACT_SEND   = 2'd1,
        ACT_RETX   = 2'd2,
        ACT_EOT    = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_STALE     = 3'd2,
        ST_BEYOND    = 3'd3,
        ST_NOT_EMPTY = 3'd4,
        ST_EXHAUSTED = 3'd5
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RETX = 1'b1
    } t_state;

    typedef struct packed {
        t_op         op;
        logic [1:0]  packet_kind;
        logic [9:0]  payload_length;
        logic [15:0] ack_number;
    } t_cmd;

    typedef struct packed {
        t_action     action;
        logic [15:0] seq_out;
        logic [1:0]  kind_out;
        logic [9:0]  length_out;
        logic [15:0] retry_count;
        t_status     status;
        logic [15:0] window_base;
        logic [3:0]  in_flight;
        logic        last;
    } t_result;

    // slot descriptor kept in the slot memory
    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  length;
        logic [15:0] retries;
    } t_slot;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic round_begin;
        logic retx_step;
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic window_empty;
        logic retx_last;
    } t_dp_status;

endpackage

/* rtl/core/gbn_ctrl.sv */
`timescale 1ns / 1ps
// Controller of the go-back-N sender window: idle / retransmit walk.
// Depends on gbn_pkg.
module gbn_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  gbn_pkg::t_op        i_op,
    input  gbn_pkg::t_dp_status i_dp,
    output logic                o_busy,
    output gbn_pkg::t_ctrl_cmd  o_cmd
);

    gbn_pkg::t_state r_state, n_state;
    logic            accept;

    assign accept = i_start && (r_state == gbn_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gbn_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gbn_pkg::S_IDLE: begin
                if (accept && i_op == gbn_pkg::OP_ROUND && !i_dp.window_empty) begin
                    n_state = gbn_pkg::S_RETX;
                end
            end
            gbn_pkg::S_RETX: begin
                if (i_dp.retx_last) begin
                    n_state = gbn_pkg::S_IDLE;
                end
            end
            default: n_state = gbn_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_busy            = 1'b0;
        o_cmd.accept      = 1'b0;
        o_cmd.round_begin = 1'b0;
        o_cmd.retx_step   = 1'b0;
        unique case (r_state)
            gbn_pkg::S_IDLE: begin
                o_cmd.accept      = accept;
                o_cmd.round_begin = accept && i_op == gbn_pkg::OP_ROUND
                                    && !i_dp.window_empty;
            end
            gbn_pkg::S_RETX: begin
                o_busy          = 1'b1;
                o_cmd.retx_step = 1'b1;
            end
            default: o_busy = 1'b0;
        endcase
    end

endmodule

/* rtl/core/gbn_dpath.sv */
`timescale 1ns / 1ps
// Datapath of the go-back-N sender window: sequence registers, slot memory,
// retransmit iterator and result register. Depends on gbn_pkg.
module gbn_dpath #(
    parameter int MAX_WINDOW  = gbn_pkg::MAX_WINDOW_DEF,
    parameter int SEQ_BITS    = gbn_pkg::SEQ_BITS_DEF,
    parameter int MAX_PAYLOAD = gbn_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [gbn_pkg::CFG_W-1:0] i_cfg_data,
    input  gbn_pkg::t_cmd             i_cmd,
    input  gbn_pkg::t_ctrl_cmd        i_ctrl,
    output gbn_pkg::t_dp_status       o_dp,
    output logic                      o_res_valid,
    output gbn_pkg::t_result          o_res
);

    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W  = (CNT_W > gbn_pkg::CFG_W) ? CNT_W : gbn_pkg::CFG_W;
    localparam int BSL_W  = ((SLOT_W > CNT_W) ? SLOT_W : CNT_W) + 1;
    localparam int PL_W0  = $clog2(MAX_PAYLOAD + 1);
    localparam int PL_W   = (PL_W0 > 10) ? PL_W0 : 10;
    localparam logic [SEQ_BITS-1:0] SEQ_LIMIT = '1;
    localparam logic [SLOT_W-1:0]   SLOT_LAST = SLOT_W'(MAX_WINDOW - 1);

    logic [gbn_pkg::CFG_W-1:0] r_window;
    logic [SEQ_BITS-1:0]       r_base, r_next, n_base, n_next;
    logic [SLOT_W-1:0]         r_next_slot, n_next_slot;
    logic [SEQ_BITS-1:0]       r_cur_seq;
    logic [SLOT_W-1:0]         r_cur_slot;
    logic [CNT_W-1:0]          r_remain;
    gbn_pkg::t_slot            r_mem [MAX_WINDOW];
    gbn_pkg::t_slot            r_rdata;
    gbn_pkg::t_result          r_res, n_res;
    logic                      r_res_valid, n_res_valid;

    logic [CNT_W-1:0]    inflight;
    logic [SEQ_BITS-1:0] diff_seq;
    logic [CMP_W-1:0]    eff_window;
    logic [BSL_W-1:0]    base_diff;
    logic [SLOT_W-1:0]   base_slot, raddr;
    logic [SEQ_BITS-1:0] ack_m, ack_p1;
    logic [1:0]          new_kind;
    logic [9:0]          new_len;
    logic [15:0]         retry_inc;
    logic                mem_we;
    logic [SLOT_W-1:0]   waddr;
    gbn_pkg::t_slot      wdata;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_LAST) ? '0 : s + 1'b1;
    endfunction

    // in flight never exceeds MAX_WINDOW, so the difference fits the count
    assign diff_seq = r_next - r_base;
    assign inflight = CNT_W'(diff_seq);

    always_comb begin
        eff_window = CMP_W'(r_window);
        if (r_window == '0) begin
            eff_window = CMP_W'(1);
        end else if (CMP_W'(r_window) > CMP_W'(MAX_WINDOW)) begin
            eff_window = CMP_W'(MAX_WINDOW);
        end
    end

    // base slot from the next slot, one wrap at most
    always_comb begin
        base_diff = BSL_W'(r_next_slot) - BSL_W'(inflight);
        if (BSL_W'(r_next_slot) < BSL_W'(inflight)) begin
            base_diff = base_diff + BSL_W'(MAX_WINDOW);
        end
        base_slot = SLOT_W'(base_diff);
    end

    assign raddr     = i_ctrl.retx_step ? slot_inc(r_cur_slot) : base_slot;
    assign ack_m     = SEQ_BITS'(i_cmd.ack_number);
    assign ack_p1    = ack_m + 1'b1;
    assign new_kind  = (i_cmd.packet_kind == gbn_pkg::KIND_NAME) ? gbn_pkg::KIND_NAME
                                                                 : gbn_pkg::KIND_DATA;
    assign new_len   = (PL_W'(i_cmd.payload_length) > PL_W'(MAX_PAYLOAD))
                       ? 10'(MAX_PAYLOAD) : i_cmd.payload_length;
    assign retry_inc = (r_rdata.retries == gbn_pkg::RETRY_MAX)
                       ? r_rdata.retries : r_rdata.retries + 1'b1;

    assign o_dp.window_empty = (inflight == '0);
    assign o_dp.retx_last    = (r_remain == CNT_W'(1));

    always_comb begin
        n_base      = r_base;
        n_next      = r_next;
        n_next_slot = r_next_slot;
        n_res_valid = 1'b0;
        n_res       = r_res;
        mem_we      = 1'b0;
        waddr       = r_next_slot;
        wdata       = '{kind: new_kind, length: new_len, retries: 16'd0};

        n_res.action      = gbn_pkg::ACT_STATUS;
        n_res.seq_out     = '0;
        n_res.kind_out    = gbn_pkg::KIND_NONE;
        n_res.length_out  = '0;
        n_res.retry_count = '0;
        n_res.status      = gbn_pkg::ST_OK;
        n_res.last        = 1'b1;

        if (i_ctrl.retx_step) begin
            n_res_valid       = 1'b1;
            n_res.action      = gbn_pkg::ACT_RETX;
            n_res.seq_out     = 16'(r_cur_seq);
            n_res.kind_out    = r_rdata.kind;
            n_res.length_out  = r_rdata.length;
            n_res.retry_count = retry_inc;
            n_res.last        = (r_remain == CNT_W'(1));
            mem_we            = 1'b1;
            waddr             = r_cur_slot;
            wdata             = '{kind: r_rdata.kind, length: r_rdata.length,
                                  retries: retry_inc};
        end else if (i_ctrl.accept) begin
            unique case (i_cmd.op)
                gbn_pkg::OP_NEW: begin
                    n_res_valid = 1'b1;
                    if (r_next == SEQ_LIMIT) begin
                        n_res.status = gbn_pkg::ST_EXHAUSTED;
                    end else if (CMP_W'(inflight) >= eff_window) begin
                        n_res.status = gbn_pkg::ST_FULL;
                    end else begin
                        mem_we           = 1'b1;
                        n_next           = r_next + 1'b1;
                        n_next_slot      = slot_inc(r_next_slot);
                        n_res.action     = gbn_pkg::ACT_SEND;
                        n_res.seq_out    = 16'(r_next);
                        n_res.kind_out   = new_kind;
                        n_res.length_out = new_len;
                    end
                end
                gbn_pkg::OP_ACK: begin
                    n_res_valid = 1'b1;
                    if (ack_m < r_base) begin
                        n_res.status = gbn_pkg::ST_STALE;
                    end else if (ack_m >= r_next) begin
                        n_res.status = gbn_pkg::ST_BEYOND;
                    end else begin
                        n_base = ack_p1;
                    end
                end
                gbn_pkg::OP_ROUND: begin
                    // nothing in flight: a single status-only transaction
                    n_res_valid = (inflight == '0);
                end
                gbn_pkg::OP_FINISH: begin
                    n_res_valid = 1'b1;
                    if (inflight != '0) begin
                        n_res.status = gbn_pkg::ST_NOT_EMPTY;
                    end else begin
                        n_res.action   = gbn_pkg::ACT_EOT;
                        n_res.seq_out  = 16'(r_next);
                        n_res.kind_out = gbn_pkg::KIND_EOT;
                    end
                end
                default: n_res_valid = 1'b0;
            endcase
        end

        n_res.window_base = 16'(n_base);
        n_res.in_flight   = 4'(n_next - n_base);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= gbn_pkg::WINDOW_RESET;
            r_base      <= '0;
            r_next      <= '0;
            r_next_slot <= '0;
            r_remain    <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_data;
            end
            r_base      <= n_base;
            r_next      <= n_next;
            r_next_slot <= n_next_slot;
            r_res_valid <= n_res_valid;
            if (i_ctrl.round_begin) begin
                r_remain <= inflight;
            end else if (i_ctrl.retx_step) begin
                r_remain <= r_remain - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (i_ctrl.round_begin) begin
            r_cur_seq  <= r_base;
            r_cur_slot <= base_slot;
        end else if (i_ctrl.retx_step) begin
            r_cur_seq  <= r_cur_seq + 1'b1;
            r_cur_slot <= slot_inc(r_cur_slot);
        end
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

/* rtl/core/go_back_n_sender_window.sv */
`timescale 1ns / 1ps
// Go-back-N sender window controller, top level.
// Depends on gbn_pkg, gbn_ctrl and gbn_dpath.
//
// A command is taken when start is high and busy is low. New-packet, ack and
// finish commands, and a round-end command with an empty window, leave busy
// low, and the single result appears on o_res with o_res_valid high in the
// next cycle. A round-end command with N packets in flight (N from 1 to
// MAX_WINDOW) walks the slot memory one slot per cycle through its one read
// port and one write port: busy is high while the walk runs and N retransmit
// results follow on consecutive cycles, the last one with o_res.last set.
// Each result is valid for exactly one cycle and there is no back-pressure,
// so the receiver must capture every strobed transaction. The window size
// register is written through the cfg channel; the user must write it only
// while the block is idle, as the block itself does not enforce this.
module go_back_n_sender_window #(
    parameter int MAX_WINDOW  = gbn_pkg::MAX_WINDOW_DEF,
    parameter int SEQ_BITS    = gbn_pkg::SEQ_BITS_DEF,
    parameter int MAX_PAYLOAD = gbn_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  gbn_pkg::t_cmd             i_cmd,
    output logic                      o_res_valid,
    output gbn_pkg::t_result          o_res,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [gbn_pkg::CFG_W-1:0] i_cfg_data
);

    gbn_pkg::t_ctrl_cmd  ctrl;
    gbn_pkg::t_dp_status dp;

    assign o_cfg_ready = 1'b1;

    gbn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_cmd.op),
        .i_dp    (dp),
        .o_busy  (busy),
        .o_cmd   (ctrl)
    );

    gbn_dpath #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SEQ_BITS    (SEQ_BITS),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (i_cmd),
        .i_ctrl      (ctrl),
        .o_dp        (dp),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule
